@@ rtl/sibt_pkg.sv @@
`default_nettype none
package sibt_pkg;

  // Table sizing
  localparam int MAX_CHUNKS = 1024;
  localparam int DEPTH      = MAX_CHUNKS + 2;
  localparam int IDX_W      = $clog2(DEPTH);

  // Chunk type codes
  localparam logic [15:0] TYPE_RAW  = 16'hcac1;
  localparam logic [15:0] TYPE_FILL = 16'hcac2;
  localparam logic [15:0] TYPE_HOLE = 16'hcac3;
  localparam logic [15:0] TYPE_CSUM = 16'hcac4;

  // Limits
  localparam logic [24:0] BS_MAX  = 25'(16 << 20);
  localparam logic [22:0] HDR_MAX = 23'(4 << 20);
  localparam logic [15:0] CHS_MIN = 16'd12;
  localparam logic [15:0] FCO_MIN = 16'd28;

  // Opcodes
  localparam logic [1:0] OP_HDR    = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // Result status codes
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_SHORT     = 4'd1;
  localparam logic [3:0] ST_TRUNC     = 4'd2;
  localparam logic [3:0] ST_OVERSIZE  = 4'd3;
  localparam logic [3:0] ST_BAD_CSUM  = 4'd4;
  localparam logic [3:0] ST_EMPTY     = 4'd5;
  localparam logic [3:0] ST_BAD_RAW   = 4'd6;
  localparam logic [3:0] ST_BAD_FILL  = 4'd7;
  localparam logic [3:0] ST_BAD_HOLE  = 4'd8;
  localparam logic [3:0] ST_UNKNOWN   = 4'd9;
  localparam logic [3:0] ST_FULL      = 4'd10;
  localparam logic [3:0] ST_RANGE     = 4'd11;
  localparam logic [3:0] ST_NOT_READY = 4'd12;

  // Source kinds
  localparam logic [1:0] K_ZERO = 2'd0;
  localparam logic [1:0] K_FILL = 2'd1;
  localparam logic [1:0] K_FILE = 2'd2;

  // Load phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_LOAD  = 2'd1;
  localparam logic [1:0] PH_READY = 2'd2;
  localparam logic [1:0] PH_FAIL  = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_BS  = 3'd0;
  localparam logic [2:0] REG_TB  = 3'd1;
  localparam logic [2:0] REG_CHS = 3'd2;
  localparam logic [2:0] REG_FCO = 3'd3;
  localparam logic [2:0] REG_FS  = 3'd4;

  // Table read address selects
  localparam logic [2:0] RD_CACHED  = 3'd0;
  localparam logic [2:0] RD_CACHED1 = 3'd1;
  localparam logic [2:0] RD_MID     = 3'd2;
  localparam logic [2:0] RD_NR      = 3'd3;
  localparam logic [2:0] RD_NR1     = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] doff;
    logic [31:0] first;
    logic [31:0] fill;
  } sibt_entry_t;

  typedef struct packed {
    logic       load_in;
    logic       start;
    logic       hdr_mul;
    logic       hdr_eval;
    logic       fin_tail;
    logic       fin_end;
    logic       res_set;
    logic [3:0] res_code;
    logic       div_start;
    logic       div_step;
    logic [2:0] rd_sel;
    logic       lo_latch;
    logic       srch_init;
    logic       srch_step;
    logic       srch_pick;
    logic       hit_pick;
    logic       ent_latch;
    logic       hi_mul;
    logic       end_mul;
    logic       rd_final;
  } sibt_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] phase;
    logic       cfg_bad;
    logic       rng_bad;
    logic       len_zero;
    logic       div_last;
    logic       cache_hit;
    logic       srch_more;
  } sibt_stat_t;

endpackage
`default_nettype wire

@@ rtl/sparse_image_block_translator_core.sv @@
`default_nettype none
// Sparse image chunk map. Chunk headers load one request at a time into a
// 1026-entry table (one write port and one registered read per cycle, no
// clearing pass after reset); a finish request closes the table, and read
// requests are then mapped to one chunk each. One request is in flight at a
// time and its result is held until taken; the next request is accepted the
// cycle after the result leaves. The first header or finish request starts
// the load and latches the configuration. A read first divides the offset
// by the block size bit-serially, then checks the cached chunk and, on a
// miss, runs a binary search of up to eleven steps, each of which reads the
// midpoint entry on the table read port and then compares against it.
module sparse_image_block_translator_core import sibt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [15:0] chunk_kind,
  input  wire logic [31:0] chunk_blocks,
  input  wire logic [31:0] chunk_stored_bytes,
  input  wire logic [31:0] fill_word,
  input  wire logic [55:0] request_offset,
  input  wire logic [31:0] request_length,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       status,
  output logic [1:0]       source_kind,
  output logic [47:0]      file_offset,
  output logic [31:0]      granted_length,
  output logic [31:0]      fill_pattern,
  output logic [10:0]      chunk_index,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);

  sibt_cmd_t        cmd;
  sibt_stat_t       st;
  logic [IDX_W-1:0] idx;

  assign chunk_index = 11'(idx);

  // Sequencer
  sibt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // Table, divider, multiplier and result register
  sibt_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .st                 (st),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .opcode             (opcode),
    .chunk_kind         (chunk_kind),
    .chunk_blocks       (chunk_blocks),
    .chunk_stored_bytes (chunk_stored_bytes),
    .fill_word          (fill_word),
    .request_offset     (request_offset),
    .request_length     (request_length),
    .status             (status),
    .source_kind        (source_kind),
    .file_offset        (file_offset),
    .granted_length     (granted_length),
    .fill_pattern       (fill_pattern),
    .chunk_index        (idx)
  );

endmodule
`default_nettype wire

@@ rtl/sibt_ctrl.sv @@
`default_nettype none
module sibt_ctrl import sibt_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire sibt_stat_t st,
  output sibt_cmd_t       cmd
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_START = 5'd2;
  localparam logic [4:0] S_HMUL  = 5'd3;
  localparam logic [4:0] S_HEVAL = 5'd4;
  localparam logic [4:0] S_FIN1  = 5'd5;
  localparam logic [4:0] S_FIN2  = 5'd6;
  localparam logic [4:0] S_DIV   = 5'd7;
  localparam logic [4:0] S_CA    = 5'd8;
  localparam logic [4:0] S_CB    = 5'd9;
  localparam logic [4:0] S_CC    = 5'd10;
  localparam logic [4:0] S_SRCH  = 5'd11;
  localparam logic [4:0] S_SCMP  = 5'd12;
  localparam logic [4:0] S_FETCH = 5'd13;
  localparam logic [4:0] S_F1    = 5'd14;
  localparam logic [4:0] S_F2    = 5'd15;
  localparam logic [4:0] S_F3    = 5'd16;
  localparam logic [4:0] S_F4    = 5'd17;
  localparam logic [4:0] S_OUT   = 5'd18;

  logic [4:0] state, state_next;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.rd_sel = RD_CACHED;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (st.op == OP_HDR || st.op == OP_FINISH) begin
          if (st.phase == PH_IDLE) begin
            state_next = S_START;
          end else if (st.phase == PH_LOAD) begin
            state_next = (st.op == OP_HDR) ? S_HMUL : S_FIN1;
          end else begin
            cmd.res_set = 1'b1;
            cmd.res_code = ST_NOT_READY;
            state_next = S_OUT;
          end
        end else if (st.op == OP_READ && st.phase == PH_READY) begin
          if (st.rng_bad) begin
            cmd.res_set = 1'b1;
            cmd.res_code = ST_RANGE;
            state_next = S_OUT;
          end else if (st.len_zero) begin
            cmd.res_set = 1'b1;
            cmd.res_code = ST_OK;
            state_next = S_OUT;
          end else begin
            cmd.div_start = 1'b1;
            state_next = S_DIV;
          end
        end else begin
          cmd.res_set = 1'b1;
          cmd.res_code = ST_NOT_READY;
          state_next = S_OUT;
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        if (st.cfg_bad) begin
          cmd.res_set = 1'b1;
          cmd.res_code = ST_NOT_READY;
          state_next = S_OUT;
        end else begin
          state_next = (st.op == OP_HDR) ? S_HMUL : S_FIN1;
        end
      end
      S_HMUL: begin
        cmd.hdr_mul = 1'b1;
        state_next = S_HEVAL;
      end
      S_HEVAL: begin
        cmd.hdr_eval = 1'b1;
        state_next = S_OUT;
      end
      S_FIN1: begin
        cmd.fin_tail = 1'b1;
        state_next = S_FIN2;
      end
      S_FIN2: begin
        cmd.fin_end = 1'b1;
        cmd.res_set = 1'b1;
        cmd.res_code = ST_OK;
        state_next = S_OUT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_next = S_CA;
      end
      S_CA: begin
        cmd.rd_sel = RD_CACHED;
        state_next = S_CB;
      end
      S_CB: begin
        cmd.lo_latch = 1'b1;
        cmd.rd_sel = RD_CACHED1;
        state_next = S_CC;
      end
      S_CC: begin
        if (st.cache_hit) begin
          cmd.hit_pick = 1'b1;
          state_next = S_FETCH;
        end else begin
          cmd.srch_init = 1'b1;
          state_next = S_SRCH;
        end
      end
      S_SRCH: begin
        cmd.rd_sel = RD_MID;
        if (st.srch_more) begin
          state_next = S_SCMP;
        end else begin
          cmd.srch_pick = 1'b1;
          state_next = S_FETCH;
        end
      end
      S_SCMP: begin
        cmd.srch_step = 1'b1;
        state_next = S_SRCH;
      end
      S_FETCH: begin
        cmd.rd_sel = RD_NR;
        state_next = S_F1;
      end
      S_F1: begin
        cmd.ent_latch = 1'b1;
        cmd.rd_sel = RD_NR1;
        state_next = S_F2;
      end
      S_F2: begin
        cmd.hi_mul = 1'b1;
        state_next = S_F3;
      end
      S_F3: begin
        cmd.end_mul = 1'b1;
        state_next = S_F4;
      end
      S_F4: begin
        cmd.rd_final = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/sibt_dp.sv @@
`default_nettype none
module sibt_dp import sibt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire sibt_cmd_t   cmd,
  output sibt_stat_t       st,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data,
  input  wire logic [1:0]  opcode,
  input  wire logic [15:0] chunk_kind,
  input  wire logic [31:0] chunk_blocks,
  input  wire logic [31:0] chunk_stored_bytes,
  input  wire logic [31:0] fill_word,
  input  wire logic [55:0] request_offset,
  input  wire logic [31:0] request_length,
  output logic [3:0]       status,
  output logic [1:0]       source_kind,
  output logic [47:0]      file_offset,
  output logic [31:0]      granted_length,
  output logic [31:0]      fill_pattern,
  output logic [IDX_W-1:0] chunk_index
);

  // Configuration registers and copies latched at load start
  logic [24:0] cfg_bs, lat_bs;
  logic [31:0] cfg_tb, lat_tb;
  logic [15:0] cfg_chs, lat_chs;
  logic [15:0] cfg_fco;
  logic [47:0] cfg_fs, lat_fs;

  // Request fields
  logic [1:0]  op_r;
  logic [15:0] type_r;
  logic [31:0] nblk_r, total_r, fillw_r, len_r;
  logic [55:0] off_r;

  // Loader / table state
  logic [1:0]       phase;
  logic [IDX_W-1:0] count, cached;
  logic [47:0]      nho;
  logic [31:0]      bm;
  logic [56:0]      img_bytes;
  logic [22:0]      hs;

  // Chunk table
  sibt_entry_t      mem [DEPTH];
  sibt_entry_t      rd_q, wd;
  logic [IDX_W-1:0] rd_addr;
  logic             we;

  // Search, divider, multiplier
  logic [IDX_W-1:0] lo, hi, mid, nr;
  logic [24:0]      rem;
  logic [31:0]      quo;
  logic [4:0]       div_cnt;
  logic [25:0]      trial;
  logic             trial_ge;
  logic [31:0]      mul_a;
  logic [56:0]      mul_p, start_r;
  logic [31:0]      fb_lo, fb_hi, fill_e;
  logic [1:0]       kind_e;
  logic [47:0]      doff_e;

  // Config write port
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_bs  <= 25'd4096;
      cfg_tb  <= 32'd1;
      cfg_chs <= 16'd12;
      cfg_fco <= 16'd28;
      cfg_fs  <= 48'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BS:  cfg_bs  <= cfg_data[24:0];
        REG_TB:  cfg_tb  <= cfg_data[31:0];
        REG_CHS: cfg_chs <= cfg_data[15:0];
        REG_FCO: cfg_fco <= cfg_data[15:0];
        REG_FS:  cfg_fs  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r    <= opcode;
      type_r  <= chunk_kind;
      nblk_r  <= chunk_blocks;
      total_r <= chunk_stored_bytes;
      fillw_r <= fill_word;
      off_r   <= request_offset;
      len_r   <= request_length;
    end
  end

  // Configuration sanity at load start
  logic cfg_bad;
  assign cfg_bad = (cfg_bs == 25'd0) || (cfg_bs[1:0] != 2'd0) || (cfg_bs > BS_MAX) ||
                   (cfg_tb == 32'd0) || (cfg_chs < CHS_MIN) || (cfg_fco < FCO_MIN);

  // Header checks
  logic [31:0] stored, room;
  logic [48:0] noff;
  logic [3:0]  hdr_st;
  logic [1:0]  hdr_kind;
  logic        hdr_add, hdr_adv, hs_full;

  assign hs_full = (hs >= HDR_MAX);
  assign stored  = total_r - {16'd0, lat_chs};
  assign noff    = {1'b0, nho} + {17'd0, total_r};
  assign room    = lat_tb - bm;

  always_comb begin
    hdr_st   = ST_OK;
    hdr_kind = K_ZERO;
    hdr_add  = 1'b0;
    hdr_adv  = 1'b0;
    if (hs_full) begin
      hdr_st = ST_FULL;
    end else if (total_r < {16'd0, lat_chs}) begin
      hdr_st = ST_SHORT;
    end else if (noff > {1'b0, lat_fs}) begin
      hdr_st = ST_TRUNC;
    end else if (nblk_r > room) begin
      hdr_st = ST_OVERSIZE;
    end else if (type_r == TYPE_CSUM) begin
      if (nblk_r != 32'd0 || stored != 32'd4) hdr_st = ST_BAD_CSUM;
      else hdr_adv = 1'b1;
    end else if (nblk_r == 32'd0) begin
      hdr_st = ST_EMPTY;
    end else begin
      case (type_r)
        TYPE_RAW: begin
          hdr_kind = K_FILE;
          if (mul_p != {25'd0, stored}) hdr_st = ST_BAD_RAW;
        end
        TYPE_FILL: begin
          hdr_kind = K_FILL;
          if (stored != 32'd4) hdr_st = ST_BAD_FILL;
        end
        TYPE_HOLE: begin
          hdr_kind = K_ZERO;
          if (stored != 32'd0) hdr_st = ST_BAD_HOLE;
        end
        default: hdr_st = ST_UNKNOWN;
      endcase
      if (hdr_st == ST_OK) begin
        if (count >= IDX_W'(MAX_CHUNKS)) begin
          hdr_st = ST_FULL;
        end else begin
          hdr_add = 1'b1;
          hdr_adv = 1'b1;
        end
      end
    end
  end

  // Table write
  logic tail_need;
  assign tail_need = (bm < lat_tb);

  always_comb begin
    we = 1'b0;
    wd = '0;
    if (cmd.hdr_eval && hdr_add) begin
      we = 1'b1;
      wd.kind  = hdr_kind;
      wd.doff  = nho + {32'd0, lat_chs};
      wd.first = bm;
      wd.fill  = (hdr_kind == K_FILL) ? fillw_r : 32'd0;
    end else if (cmd.fin_tail && tail_need) begin
      we = 1'b1;
      wd.first = bm;
    end else if (cmd.fin_end) begin
      we = 1'b1;
      wd.first = lat_tb;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[count] <= wd;
  end

  // Table read port
  assign mid = lo + ((hi - lo) >> 1);

  always_comb begin
    case (cmd.rd_sel)
      RD_CACHED:  rd_addr = cached;
      RD_CACHED1: rd_addr = cached + 1'b1;
      RD_MID:     rd_addr = mid;
      RD_NR:      rd_addr = nr;
      RD_NR1:     rd_addr = nr + 1'b1;
      default:    rd_addr = cached;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_q <= mem[rd_addr];
  end

  // Shared multiplier: operand times latched block size
  always_comb begin
    mul_a = fb_hi;
    if (cmd.hdr_mul)      mul_a = nblk_r;
    else if (cmd.fin_tail) mul_a = lat_tb;
    else if (cmd.hi_mul)   mul_a = fb_lo;
  end

  always_ff @(posedge clk) begin
    if (cmd.hdr_mul || cmd.fin_tail || cmd.hi_mul || cmd.end_mul) begin
      mul_p <= 57'(mul_a) * 57'(lat_bs);
    end
    if (cmd.end_mul) start_r <= mul_p;
  end

  // Restoring divider: offset / block size, one quotient bit per cycle
  assign trial    = {rem, quo[31]};
  assign trial_ge = (trial >= {1'b0, lat_bs});

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem     <= {1'b0, off_r[55:32]};
      quo     <= off_r[31:0];
      div_cnt <= 5'd0;
    end else if (cmd.div_step) begin
      rem     <= trial_ge ? 25'(trial - {1'b0, lat_bs}) : trial[24:0];
      quo     <= {quo[30:0], trial_ge};
      div_cnt <= div_cnt + 5'd1;
    end
  end

  // Search and entry latches
  always_ff @(posedge clk) begin
    if (cmd.lo_latch) fb_lo <= rd_q.first;
    if (cmd.srch_init) begin
      lo <= '0;
      hi <= count - 1'b1;
    end else if (cmd.srch_step) begin
      if (quo < rd_q.first) hi <= mid;
      else lo <= mid;
    end
    if (cmd.hit_pick)  nr <= cached;
    if (cmd.srch_pick) nr <= lo;
    if (cmd.ent_latch) begin
      kind_e <= rd_q.kind;
      doff_e <= rd_q.doff;
      fill_e <= rd_q.fill;
      fb_lo  <= rd_q.first;
    end
    if (cmd.hi_mul) fb_hi <= rd_q.first;
  end

  // Final read mapping
  logic [56:0] chunk_rel, avail;
  logic [31:0] glen, rot;

  assign chunk_rel = {1'b0, off_r} - start_r;
  assign avail     = mul_p - {1'b0, off_r};
  assign glen      = ({25'd0, len_r} > avail) ? avail[31:0] : len_r;

  always_comb begin
    case (chunk_rel[1:0])
      2'd0:    rot = fill_e;
      2'd1:    rot = {fill_e[7:0], fill_e[31:8]};
      2'd2:    rot = {fill_e[15:0], fill_e[31:16]};
      default: rot = {fill_e[23:0], fill_e[31:24]};
    endcase
  end

  // Control state of the loader
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      count     <= '0;
      cached    <= '0;
      nho       <= 48'd28;
      bm        <= 32'd0;
      img_bytes <= 57'd0;
      hs        <= 23'd0;
      lat_bs    <= 25'd4096;
      lat_tb    <= 32'd1;
      lat_chs   <= 16'd12;
      lat_fs    <= 48'd0;
    end else begin
      if (cmd.start) begin
        lat_bs  <= cfg_bs;
        lat_tb  <= cfg_tb;
        lat_chs <= cfg_chs;
        lat_fs  <= cfg_fs;
        nho     <= {32'd0, cfg_fco};
        phase   <= cfg_bad ? PH_FAIL : PH_LOAD;
      end
      if (cmd.hdr_eval) begin
        if (!hs_full) hs <= hs + 23'd1;
        if (hdr_st != ST_OK) phase <= PH_FAIL;
        if (hdr_adv) nho <= noff[47:0];
        if (hdr_add) begin
          count <= count + 1'b1;
          bm    <= bm + nblk_r;
        end
      end
      if (cmd.fin_tail && tail_need) count <= count + 1'b1;
      if (cmd.fin_end) begin
        count     <= count + 1'b1;
        img_bytes <= mul_p;
        cached    <= '0;
        phase     <= PH_READY;
      end
      if (cmd.srch_pick) cached <= lo;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      status         <= cmd.res_code;
      source_kind    <= K_ZERO;
      file_offset    <= '0;
      granted_length <= '0;
      fill_pattern   <= '0;
      chunk_index    <= '0;
    end else if (cmd.hdr_eval) begin
      status         <= hdr_st;
      source_kind    <= K_ZERO;
      file_offset    <= '0;
      granted_length <= '0;
      fill_pattern   <= '0;
      chunk_index    <= '0;
    end else if (cmd.rd_final) begin
      status         <= ST_OK;
      source_kind    <= kind_e;
      file_offset    <= (kind_e == K_FILE) ? doff_e + chunk_rel[47:0] : 48'd0;
      granted_length <= glen;
      fill_pattern   <= (kind_e == K_FILL) ? rot : 32'd0;
      chunk_index    <= nr;
    end
  end

  // Status to controller
  logic [IDX_W:0] cached_p1;
  assign cached_p1 = {1'b0, cached} + 1'b1;

  assign st.op        = op_r;
  assign st.phase     = phase;
  assign st.cfg_bad   = cfg_bad;
  assign st.rng_bad   = ({1'b0, off_r} > img_bytes) ||
                        ({25'd0, len_r} > (img_bytes - {1'b0, off_r}));
  assign st.len_zero  = (len_r == 32'd0);
  assign st.div_last  = (div_cnt == 5'd31);
  assign st.cache_hit = (cached_p1 < {1'b0, count}) && (quo >= fb_lo) &&
                        (quo < rd_q.first);
  assign st.srch_more = ((hi - lo) > 1);

  // A ready table always holds at least one chunk and the sentinel
  a_ready_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_READY) |-> (count >= IDX_W'(2)))
    else $error("ready table has fewer than two entries");

  // The cached entry always has a successor in the table
  a_cache_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_READY) |-> (cached_p1 < {1'b0, count}))
    else $error("cached entry out of table bounds");

  // Entry count never shrinks and never exceeds the table depth
  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ((count >= $past(count)) && (count <= IDX_W'(DEPTH))))
    else $error("entry count moved backward or overflowed");

  // Search window stays ordered
  a_search_order: assert property (@(posedge clk) disable iff (rst)
    cmd.srch_step |=> (lo < hi))
    else $error("binary search window collapsed");

endmodule
`default_nettype wire

@@ verif/chunk_map_checker.sv @@
`timescale 1ns / 1ps
module chunk_map_checker import sibt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [15:0] chunk_kind,
  input  wire logic [31:0] chunk_blocks,
  input  wire logic [31:0] chunk_stored_bytes,
  input  wire logic [31:0] fill_word,
  input  wire logic [55:0] request_offset,
  input  wire logic [31:0] request_length,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [3:0]  status,
  input  wire logic [1:0]  source_kind,
  input  wire logic [47:0] file_offset,
  input  wire logic [31:0] granted_length,
  input  wire logic [31:0] fill_pattern,
  input  wire logic [10:0] chunk_index,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data,
  output int               pending_count,
  output int               error_count
);

  typedef struct packed {
    logic [3:0]  status;
    logic [1:0]  kind;
    logic [47:0] foff;
    logic [31:0] glen;
    logic [31:0] pat;
    logic [10:0] idx;
  } answer_t;

  localparam longint unsigned MASK48 = 64'hFFFF_FFFF_FFFF;

  answer_t pending_answers[$];

  // programmed registers and the copy taken at load start
  longint unsigned wr_bs, wr_tb, wr_chs, wr_fco, wr_fs;
  longint unsigned cur_bs, cur_tb, cur_chs, cur_fs;

  // chunk table
  logic [1:0]  tbl_kind  [DEPTH];
  logic [47:0] tbl_doff  [DEPTH];
  logic [31:0] tbl_first [DEPTH];
  logic [31:0] tbl_fill  [DEPTH];
  int unsigned     n_entries, last_hit, hdr_seen;
  longint unsigned hdr_pos, img_bytes;
  logic [31:0]     mapped;
  logic [1:0]      phase;

  function automatic logic [3:0] load_header(logic [15:0] typ, longint unsigned nblk,
                                             longint unsigned stored, logic [31:0] fw);
    longint unsigned doff, rem, noff;
    logic [1:0] kind;
    if (hdr_seen >= HDR_MAX) return ST_FULL;
    hdr_seen++;
    if (stored < cur_chs) return ST_SHORT;
    doff = hdr_pos + cur_chs;
    rem  = stored - cur_chs;
    noff = hdr_pos + stored;
    if (noff > cur_fs) return ST_TRUNC;
    if (nblk > cur_tb - mapped) return ST_OVERSIZE;
    if (typ == TYPE_CSUM) begin
      if (nblk != 0 || rem != 4) return ST_BAD_CSUM;
      hdr_pos = noff;
      return ST_OK;
    end
    if (nblk == 0) return ST_EMPTY;
    if (typ == TYPE_RAW) begin
      if (nblk * cur_bs != rem) return ST_BAD_RAW;
      kind = K_FILE;
    end else if (typ == TYPE_FILL) begin
      if (rem != 4) return ST_BAD_FILL;
      kind = K_FILL;
    end else if (typ == TYPE_HOLE) begin
      if (rem != 0) return ST_BAD_HOLE;
      kind = K_ZERO;
    end else begin
      return ST_UNKNOWN;
    end
    if (n_entries >= MAX_CHUNKS) return ST_FULL;
    tbl_kind[n_entries]  = kind;
    tbl_doff[n_entries]  = doff[47:0];
    tbl_first[n_entries] = mapped;
    tbl_fill[n_entries]  = (kind == K_FILL) ? fw : 32'd0;
    n_entries++;
    mapped  = mapped + nblk[31:0];
    hdr_pos = noff;
    return ST_OK;
  endfunction

  function automatic void add_hole(logic [31:0] first);
    tbl_kind[n_entries]  = K_ZERO;
    tbl_doff[n_entries]  = '0;
    tbl_first[n_entries] = first;
    tbl_fill[n_entries]  = '0;
    n_entries++;
  endfunction

  function automatic answer_t map_read(longint unsigned off, longint unsigned len);
    answer_t a;
    longint unsigned blk, lo_b, hi_b, rel;
    int unsigned nr, lo, hi, mid, ph;
    logic [31:0] w;
    a = '0;
    if (off > img_bytes || len > img_bytes - off) begin
      a.status = ST_RANGE;
      return a;
    end
    if (len == 0) return a;
    blk = off / cur_bs;
    nr = last_hit;
    if (nr + 1 >= n_entries || blk < tbl_first[nr] || blk >= tbl_first[nr + 1]) begin
      lo = 0;
      hi = n_entries - 1;
      while (hi - lo > 1) begin
        mid = lo + (hi - lo) / 2;
        if (blk < tbl_first[mid]) hi = mid;
        else lo = mid;
      end
      nr = lo;
      last_hit = nr;
    end
    lo_b = longint'(tbl_first[nr]) * cur_bs;
    hi_b = longint'(tbl_first[nr + 1]) * cur_bs;
    rel = off - lo_b;
    if (len > hi_b - off) len = hi_b - off;
    a.kind = tbl_kind[nr];
    a.glen = len[31:0];
    a.idx  = nr[10:0];
    if (tbl_kind[nr] == K_FILE) begin
      a.foff = 48'((longint'(tbl_doff[nr]) + rel) & MASK48);
    end else if (tbl_kind[nr] == K_FILL) begin
      ph = rel[1:0];
      w = tbl_fill[nr];
      a.pat = (ph == 0) ? w : ((w >> (8 * ph)) | (w << (32 - 8 * ph)));
    end
    return a;
  endfunction

  // one answer per request
  function automatic answer_t predict(logic [1:0] op);
    answer_t a;
    logic [3:0] code;
    a = '0;
    a.status = ST_NOT_READY;
    if (op == OP_HDR || op == OP_FINISH) begin
      if (phase == PH_IDLE) begin
        cur_bs = wr_bs; cur_tb = wr_tb; cur_chs = wr_chs; cur_fs = wr_fs;
        hdr_pos = wr_fco;
        if (cur_bs == 0 || cur_bs[1:0] != 0 || cur_bs > BS_MAX || cur_tb == 0 ||
            cur_chs < CHS_MIN || wr_fco < FCO_MIN) phase = PH_FAIL;
        else phase = PH_LOAD;
      end
      if (phase == PH_LOAD) begin
        if (op == OP_HDR) begin
          a.status = load_header(chunk_kind, chunk_blocks, chunk_stored_bytes, fill_word);
          if (a.status != ST_OK) phase = PH_FAIL;
        end else begin
          if (mapped < cur_tb) add_hole(mapped);
          add_hole(cur_tb[31:0]);
          img_bytes = cur_tb * cur_bs;
          last_hit = 0;
          phase = PH_READY;
          a.status = ST_OK;
        end
      end
    end else if (op == OP_READ && phase == PH_READY) begin
      a = map_read(request_offset, request_length);
    end
    // any error answer carries only its status
    if (a.status != ST_OK) begin
      code = a.status;
      a = '0;
      a.status = code;
    end
    return a;
  endfunction

  assign pending_count = pending_answers.size();

  always @(posedge clk) begin
    answer_t exp_a, got;
    if (rst) begin
      wr_bs <= 4096; wr_tb <= 1; wr_chs <= 12; wr_fco <= 28; wr_fs <= 0;
      n_entries <= 0; last_hit <= 0; hdr_seen <= 0; hdr_pos <= 28;
      mapped <= 0; img_bytes <= 0; phase <= PH_IDLE;
      error_count <= 0;
      pending_answers.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_BS:  wr_bs  = cfg_data[24:0];
          REG_TB:  wr_tb  = cfg_data[31:0];
          REG_CHS: wr_chs = cfg_data[15:0];
          REG_FCO: wr_fco = cfg_data[15:0];
          REG_FS:  wr_fs  = cfg_data[47:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) pending_answers.push_back(predict(opcode));
      if (out_valid && !out_stall) begin
        got = '{status, source_kind, file_offset, granted_length, fill_pattern, chunk_index};
        if (pending_answers.size() == 0) begin
          $error("unexpected result, status %0d", status);
          error_count++;
        end else begin
          exp_a = pending_answers.pop_front();
          if (got.status != exp_a.status) begin
            $error("status exp %0d got %0d", exp_a.status, got.status); error_count++;
          end
          if (got.kind != exp_a.kind) begin
            $error("source_kind exp %0d got %0d", exp_a.kind, got.kind); error_count++;
          end
          if (got.foff != exp_a.foff) begin
            $error("file_offset exp %0h got %0h", exp_a.foff, got.foff); error_count++;
          end
          if (got.glen != exp_a.glen) begin
            $error("granted_length exp %0h got %0h", exp_a.glen, got.glen); error_count++;
          end
          if (got.pat != exp_a.pat) begin
            $error("fill_pattern exp %0h got %0h", exp_a.pat, got.pat); error_count++;
          end
          if (got.idx != exp_a.idx) begin
            $error("chunk_index exp %0d got %0d", exp_a.idx, got.idx); error_count++;
          end
        end
      end
    end
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
module testbench import sibt_pkg::*;;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1500000;

  logic        clk, rst;
  logic        in_valid, in_stall;
  logic [1:0]  opcode;
  logic [15:0] chunk_kind;
  logic [31:0] chunk_blocks, chunk_stored_bytes, fill_word, request_length;
  logic [55:0] request_offset;
  logic        out_valid, out_stall;
  logic [3:0]  status;
  logic [1:0]  source_kind;
  logic [47:0] file_offset;
  logic [31:0] granted_length, fill_pattern;
  logic [10:0] chunk_index;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;
  int          pending_count, error_count;

  // idle rates in percent, and the one long receiver hold-off
  int unsigned snd_idle, rcv_idle;
  bit          hold_req, hold_done;
  int unsigned cycles;

  longint unsigned bs, tb, chs, fco, img, pos, rd_off, rd_len;

  sparse_image_block_translator_core dut (.*);
  chunk_map_checker u_scoreboard (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver side
  initial begin
    out_stall <= 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1;
        repeat (400) @(posedge clk);
        hold_done = 1;
      end
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  task automatic send(logic [1:0] op, logic [15:0] typ, logic [31:0] nblk,
                      logic [31:0] stored, logic [31:0] fw, logic [55:0] off,
                      logic [31:0] len);
    in_valid <= 1;
    opcode <= op; chunk_kind <= typ; chunk_blocks <= nblk;
    chunk_stored_bytes <= stored; fill_word <= fw;
    request_offset <= off; request_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    cfg_write <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_write <= 0;
    @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic read_req(longint unsigned off, longint unsigned len);
    send(OP_READ, 16'h0, 0, 0, 0, off[55:0], len[31:0]);
  endtask

  // one well-formed chunk header of the given kind
  task automatic chunk(logic [15:0] typ, longint unsigned nblk, logic [31:0] fw);
    longint unsigned stored;
    if (typ == TYPE_RAW) stored = nblk * bs + chs;
    else if (typ == TYPE_HOLE) stored = chs;
    else stored = chs + 4;
    if (typ == TYPE_CSUM) nblk = 0;
    send(OP_HDR, typ, nblk[31:0], stored[31:0], fw, 56'($urandom), $urandom);
  endtask

  task automatic random_read;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      rd_off = pos;
    end else if (pick < 85) begin
      rd_off = {$urandom, $urandom} % (img + 1);
    end else if (pick < 92) begin
      rd_off = {$urandom, $urandom} & 64'h00FF_FFFF_FFFF_FFFF;
    end else begin
      rd_off = img - $urandom_range(0, 3);
    end
    pick = $urandom_range(99);
    if (pick < 60) rd_len = $urandom_range(1, 8);
    else if (pick < 90) rd_len = $urandom_range(0, 3 * bs);
    else rd_len = $urandom;
    if (rd_off + rd_len <= img) pos = rd_off + (rd_len == 0 ? 1 : rd_len);
    if (pos >= img) pos = 0;
    read_req(rd_off, rd_len);
  endtask

  initial begin
    int unsigned sel;
    rst = 1;
    in_valid <= 0; opcode <= 0; chunk_kind <= 0; chunk_blocks <= 0;
    chunk_stored_bytes <= 0; fill_word <= 0; request_offset <= 0; request_length <= 0;
    cfg_write <= 0; cfg_index <= 0; cfg_data <= 0;
    snd_idle = 9; rcv_idle = 79; hold_req = 0; hold_done = 0; cycles = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // settings: extremes first, then the ones latched at load start
    sel = $urandom_range(2);
    bs  = (sel == 0) ? 4 : (sel == 1) ? 16777216 : 4 * $urandom_range(2, 64);
    tb  = $urandom_range(3000, 5000);
    chs = $urandom_range(12, 40);
    fco = $urandom_range(28, 100);
    img = tb * bs;
    write_reg(REG_BS, 48'd16777216);
    write_reg(REG_TB, 48'hFFFF_FFFF);
    write_reg(REG_CHS, 48'hFFFF);
    write_reg(REG_FCO, 48'hFFFF);
    write_reg(REG_FS, 48'h0);
    write_reg(REG_BS, bs);
    write_reg(REG_TB, tb);
    write_reg(REG_CHS, chs);
    write_reg(REG_FCO, fco);
    write_reg(REG_FS, 48'hFFFF_FFFF_FFFF);

    // not ready before the load, unused opcode
    read_req(0, 1);
    send(OP_UNUSED, 16'hFFFF, '1, '1, '1, '1, '1);

    // one of each chunk kind, fill extremes
    chunk(TYPE_RAW, 1, 0);
    chunk(TYPE_FILL, 2, 32'hFFFF_FFFF);
    chunk(TYPE_CSUM, 0, 0);
    chunk(TYPE_HOLE, 3, 0);
    chunk(TYPE_FILL, 1, 32'h0);
    chunk(TYPE_FILL, 4, 32'h4433_2211);
    repeat (170) begin
      sel = $urandom_range(9);
      chunk(sel < 4 ? TYPE_RAW : sel < 7 ? TYPE_FILL : sel < 9 ? TYPE_HOLE : TYPE_CSUM,
            ($urandom_range(3) == 0) ? 1 : $urandom_range(1, 16), $urandom);
    end
    send(OP_FINISH, 0, 0, 0, 0, 0, 0);

    // read corners, then requests that are refused after the load
    read_req(0, 0);
    read_req(img, 0);
    read_req(img, 1);
    read_req(56'hFF_FFFF_FFFF_FFFF, 1);
    read_req(0, 32'hFFFF_FFFF);
    read_req(img - 1, 1);
    read_req(0, img);
    read_req(bs - 1, 2 * bs);
    read_req(bs + 1, 7);
    send(OP_HDR, TYPE_RAW, 1, bs + chs, 0, 0, 0);
    send(OP_FINISH, 0, 0, 0, 0, 0, 0);
    send(OP_UNUSED, 0, 0, 0, 0, 0, 0);

    // writes after the load must not disturb the mapping
    drain();
    write_reg(REG_BS, 48'd4);
    write_reg(REG_TB, 48'd1);
    write_reg(REG_CHS, 48'd12);
    write_reg(REG_FCO, 48'd28);
    write_reg(REG_FS, 48'hFFFF_FFFF_FFFF);

    pos = 0;
    hold_req = 1;
    for (int i = 0; i < 900; i++) begin
      if (i == 300 || i == 600) begin
        drain();
        write_reg(REG_BS, i == 300 ? 48'd8 : 48'd16777216);
        snd_idle = (i == 300) ? 79 : 0;
        rcv_idle = (i == 300) ? 9 : 0;
      end
      if ($urandom_range(99) < 8)
        send($urandom_range(3), $urandom, $urandom, $urandom, $urandom,
             {$urandom, $urandom}, $urandom);
      else
        random_read();
    end

    drain();
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
